// ----- rtl/lcg_noise_source_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the LCG noise source
// Clocked implication checks used by the controller.
// ----------------------------------------------------------------------------
`ifndef LCG_NOISE_SOURCE_UNIT_ASSERT_SVH
`define LCG_NOISE_SOURCE_UNIT_ASSERT_SVH

// same-cycle implication
`define LCGNS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LCGNS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/lcgns_pkg.sv -----
// ----------------------------------------------------------------------------
// LCG noise source package
// Widths, register and kind codes, and the controller command bundle.
// ----------------------------------------------------------------------------
package lcgns_pkg;

	localparam int unsigned WordW    = 32;
	localparam int unsigned FracW    = 24;
	localparam int unsigned DvdW     = WordW + FracW;
	localparam int unsigned ModSteps = WordW;
	localparam int unsigned DivSteps = DvdW;
	localparam int unsigned CntW     = $clog2(DivSteps);
	localparam int unsigned IdxW     = 2;
	localparam int unsigned OutW     = WordW + FracW;

	localparam logic [IdxW-1:0] RegMultiplier = 2'd0;
	localparam logic [IdxW-1:0] RegIncrement  = 2'd1;
	localparam logic [IdxW-1:0] RegModulus    = 2'd2;

	localparam logic KindAdvance = 1'b0;
	localparam logic KindReseed  = 1'b1;

	localparam logic [WordW-1:0] MultReset = 32'd1;
	localparam logic [WordW-1:0] IncReset  = 32'd1;
	localparam logic [WordW-1:0] ModReset  = 32'd65536;

	typedef struct packed {
		logic load_seed;
		logic mul;
		logic add;
		logic div_step;
		logic save_state;
		logic load_out;
	} cmd_t;

endpackage

// ----- rtl/lcgns_dp.sv -----
// ----------------------------------------------------------------------------
// LCG noise source datapath
// Config registers, state word, multiplier, and a one-bit-per-cycle
// restoring divider that yields both the modulus remainder and the scaled
// quotient from one long division of {raw, 24 zeros}.
// ----------------------------------------------------------------------------
module lcgns_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lcgns_pkg::cmd_t                    cmd,
	input  logic [lcgns_pkg::WordW-1:0]        seed,
	input  logic                               cfg_we,
	input  logic [lcgns_pkg::IdxW-1:0]         cfg_index,
	input  logic [lcgns_pkg::WordW-1:0]        cfg_data,
	output logic [lcgns_pkg::OutW-1:0]         out_word
);

	logic [lcgns_pkg::WordW-1:0] mult_q;
	logic [lcgns_pkg::WordW-1:0] inc_q;
	logic [lcgns_pkg::WordW-1:0] mod_q;
	logic [lcgns_pkg::WordW-1:0] state_q;
	logic [lcgns_pkg::WordW-1:0] prod_q;
	logic [lcgns_pkg::WordW-1:0] rem_q;
	logic [lcgns_pkg::DvdW-1:0]  dvd_q;
	logic [lcgns_pkg::OutW-1:0]  out_q;

	logic [lcgns_pkg::WordW-1:0] prod_lo;
	logic [lcgns_pkg::WordW-1:0] raw_sum;
	logic [lcgns_pkg::WordW:0]   rem_sh;
	logic [lcgns_pkg::WordW:0]   mod_ext;
	logic                        ge;
	logic [lcgns_pkg::WordW-1:0] rem_nx;
	logic [lcgns_pkg::FracW-1:0] sample;

	assign prod_lo = state_q * mult_q;
	assign raw_sum = prod_q + inc_q;
	assign rem_sh  = {rem_q, dvd_q[lcgns_pkg::DvdW-1]};
	assign mod_ext = {1'b0, mod_q};
	assign ge      = (rem_sh >= mod_ext);
	assign rem_nx  = ge ? lcgns_pkg::WordW'(rem_sh - mod_ext) : rem_sh[lcgns_pkg::WordW-1:0];

	// offset binary to two's complement: flip the top bit
	assign sample = {~dvd_q[lcgns_pkg::FracW-1], dvd_q[lcgns_pkg::FracW-2:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q  <= lcgns_pkg::MultReset;
			inc_q   <= lcgns_pkg::IncReset;
			mod_q   <= lcgns_pkg::ModReset;
			state_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					lcgns_pkg::RegMultiplier: mult_q <= cfg_data;
					lcgns_pkg::RegIncrement:  inc_q  <= cfg_data;
					lcgns_pkg::RegModulus: begin
						// drop a zero modulus
						if (cfg_data != '0) mod_q <= cfg_data;
					end
					default: ;
				endcase
			end
			if (cmd.load_seed) begin
				state_q <= seed;
			end else if (cmd.save_state) begin
				state_q <= rem_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) prod_q <= prod_lo;
		if (cmd.add) begin
			rem_q <= '0;
			dvd_q <= {raw_sum, {lcgns_pkg::FracW{1'b0}}};
		end else if (cmd.div_step) begin
			rem_q <= rem_nx;
			dvd_q <= {dvd_q[lcgns_pkg::DvdW-2:0], ge};
		end
		if (cmd.load_out) out_q <= {sample, state_q};
	end

	assign out_word = out_q;

endmodule

// ----- rtl/lcgns_ctrl.sv -----
// ----------------------------------------------------------------------------
// LCG noise source controller
// Sequences multiply, add and the divide steps, and owns the handshakes
// and the output word valid flag.
// ----------------------------------------------------------------------------
`include "lcg_noise_source_unit_assert.svh"

module lcgns_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_kind,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output lcgns_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t                        state_q;
	logic [lcgns_pkg::CntW-1:0]    cnt_q;
	logic                          out_valid_q;
	logic                          in_acc;
	logic                          cnt_last;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cnt_last  = (cnt_q == lcgns_pkg::CntW'(lcgns_pkg::DivSteps - 1));
	assign out_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.load_seed  = in_acc && (in_kind == lcgns_pkg::KindReseed);
		cmd.mul        = (state_q == ST_MUL);
		cmd.add        = (state_q == ST_ADD);
		cmd.div_step   = (state_q == ST_DIV);
		// remainder is final after the integer part of the division
		cmd.save_state = (state_q == ST_DIV) &&
			(cnt_q == lcgns_pkg::CntW'(lcgns_pkg::ModSteps - 1));
		cmd.load_out   = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (in_kind == lcgns_pkg::KindAdvance)) state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_ADD;
				ST_ADD: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_last) state_q <= ST_FIN;
				end
				ST_FIN: begin
					// hold until the output word is free
					if (cmd.load_out) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase

			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`LCGNS_ASSERT_NEXT(a_mul_to_add, clk, arst_n, state_q == ST_MUL, state_q == ST_ADD, "multiply not followed by add")
	`LCGNS_ASSERT_NEXT(a_div_count, clk, arst_n, (state_q == ST_DIV) && !cnt_last, (state_q == ST_DIV) && (cnt_q == $past(cnt_q) + 1'b1), "divide step count broken")
	`LCGNS_ASSERT_NEXT(a_fin_stall, clk, arst_n, (state_q == ST_FIN) && out_valid_q && !out_ready, state_q == ST_FIN, "result left while output word busy")
	`LCGNS_ASSERT_NEXT(a_load_out, clk, arst_n, cmd.load_out, out_valid_q && (state_q == ST_IDLE), "loaded result not presented")

endmodule

// ----- rtl/lcg_noise_source_unit.sv -----
// Advance word: accepted in idle, then multiply, add, 56 one-bit steps of the
// restoring divider and the result load, which waits while the output word is still occupied.
// The input is not ready during an advance; in idle a reseed word is taken every cycle.
// The output word register lets the next input be taken while a result waits.
// Reset (arst_n low, asynchronous): state word 0, multiplier 1, increment 1,
// modulus 65536, no result pending.
// ----------------------------------------------------------------------------
// LCG noise source top level
// Stream-in words advance or reseed the generator; advances emit raw state
// and a signed Q1.23 sample.
// ----------------------------------------------------------------------------
module lcg_noise_source_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [lcgns_pkg::WordW-1:0]          s_axis_tdata,  // [31:0] new_seed
	input  logic                                 s_axis_tuser,  // [0] kind
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [lcgns_pkg::OutW-1:0]           m_axis_tdata,  // [31:0] raw_value, [55:32] sample
	input  logic                                 cfg_we,
	input  logic [lcgns_pkg::IdxW-1:0]           cfg_index,
	input  logic [lcgns_pkg::WordW-1:0]          cfg_data
);

	lcgns_pkg::cmd_t cmd;

	lcgns_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_kind   (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	lcgns_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.seed      (s_axis_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_word  (m_axis_tdata)
	);

endmodule

// ----- test/lcg_noise_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LCG noise source checker
// Watches the input, output and register ports, keeps its own generator state
// and register copies, and compares every output word with the oldest one due.
// ----------------------------------------------------------------------------
module lcg_noise_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	input  logic                        s_axis_tready,
	input  logic [lcgns_pkg::WordW-1:0] s_axis_tdata,   // [31:0] new_seed
	input  logic                        s_axis_tuser,   // [0] kind
	input  logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	input  logic [lcgns_pkg::OutW-1:0]  m_axis_tdata,   // [31:0] raw_value, [55:32] sample
	input  logic                        cfg_we,
	input  logic [lcgns_pkg::IdxW-1:0]  cfg_index,
	input  logic [lcgns_pkg::WordW-1:0] cfg_data,
	output int                          fail_count,
	output int                          pending
);

	localparam int unsigned ReportLimit = 10;
	localparam logic [lcgns_pkg::FracW-1:0] HalfScale =
		lcgns_pkg::FracW'(1) << (lcgns_pkg::FracW - 1);

	typedef struct packed {
		logic signed [lcgns_pkg::FracW-1:0] sample;
		logic [lcgns_pkg::WordW-1:0]        raw_value;
	} noise_word_t;

	noise_word_t                 noise_due[$];
	logic [lcgns_pkg::WordW-1:0] mult_q;
	logic [lcgns_pkg::WordW-1:0] incr_q;
	logic [lcgns_pkg::WordW-1:0] mod_q;
	logic [lcgns_pkg::WordW-1:0] lcg_state;

	// one generator step from the current state and register copies
	function automatic noise_word_t next_noise(input logic [lcgns_pkg::WordW-1:0] cur);
		logic [lcgns_pkg::WordW-1:0] wrapped;
		logic [lcgns_pkg::DvdW-1:0]  scaled;
		noise_word_t                 w;
		wrapped = cur * mult_q + incr_q;
		w.raw_value = wrapped % mod_q;
		scaled = {w.raw_value, {lcgns_pkg::FracW{1'b0}}} /
			{{lcgns_pkg::FracW{1'b0}}, mod_q};
		w.sample = scaled[lcgns_pkg::FracW-1:0] - HalfScale;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		noise_word_t got;
		noise_word_t want;
		if (!arst_n) begin
			mult_q = lcgns_pkg::MultReset;
			incr_q = lcgns_pkg::IncReset;
			mod_q = lcgns_pkg::ModReset;
			lcg_state = '0;
			noise_due.delete();
			fail_count = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (noise_due.size() == 0) begin
					if (fail_count < ReportLimit)
						$display("%0t: unexpected word raw %h sample %0d",
							$realtime, got.raw_value, got.sample);
					fail_count++;
				end else begin
					want = noise_due.pop_front();
					if (got.raw_value !== want.raw_value || got.sample !== want.sample) begin
						if (fail_count < ReportLimit)
							$display("%0t: raw %h sample %0d, expected raw %h sample %0d",
								$realtime, got.raw_value, got.sample,
								want.raw_value, want.sample);
						fail_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser == lcgns_pkg::KindReseed) begin
					lcg_state = s_axis_tdata;
				end else begin
					want = next_noise(lcg_state);
					lcg_state = want.raw_value;
					noise_due.push_back(want);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					lcgns_pkg::RegMultiplier: mult_q = cfg_data;
					lcgns_pkg::RegIncrement:  incr_q = cfg_data;
					lcgns_pkg::RegModulus: begin
						// a zero modulus is refused, keep the old one
						if (cfg_data != '0)
							mod_q = cfg_data;
					end
					default: ;
				endcase
			end
		end
		pending = noise_due.size();
	end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LCG noise source testbench
// Directed seeds and register extremes, then random phases of advance and
// reseed words under bursty input and a stalling output; a checker predicts.
// ----------------------------------------------------------------------------
module tb;

	localparam int unsigned ClkHalf      = 4;
	localparam int unsigned ResetCycles  = 6;
	localparam int unsigned Phases       = 6;
	localparam int unsigned PhaseItems   = 92;
	localparam int unsigned SettleCycles = 80;
	localparam int unsigned HoldCycles   = 400;
	localparam int unsigned TimeoutNs    = 5_000_000;
	localparam logic [lcgns_pkg::IdxW-1:0] RegSpare = 2'd3;

	typedef enum int { RxFree, RxCoin, RxEveryFourth, RxSparse } rx_mode_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        s_axis_tvalid = 1'b0;
	logic                        s_axis_tready;
	logic [lcgns_pkg::WordW-1:0] s_axis_tdata = '0;   // [31:0] new_seed
	logic                        s_axis_tuser = lcgns_pkg::KindAdvance;   // [0] kind
	logic                        m_axis_tvalid;
	logic                        m_axis_tready = 1'b0;
	logic [lcgns_pkg::OutW-1:0]  m_axis_tdata;   // [31:0] raw_value, [55:32] sample
	logic                        cfg_we = 1'b0;
	logic [lcgns_pkg::IdxW-1:0]  cfg_index = lcgns_pkg::RegMultiplier;
	logic [lcgns_pkg::WordW-1:0] cfg_data = '0;

	int                          fail_count;
	int                          pending;
	logic                        hold_go = 1'b0;
	int                          burst_left = 0;
	logic [lcgns_pkg::WordW-1:0] cur_mod = lcgns_pkg::ModReset;

	lcg_noise_source_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	lcg_noise_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always begin
		#ClkHalf clk = 1'b1;
		#ClkHalf clk = 1'b0;
	end

	initial begin
		#TimeoutNs;
		$display("CHECKS FAILED");
		$finish;
	end

	// output side: stall patterns in stretches, plus one long hold on request
	initial begin
		rx_mode_t mode;
		int left;
		int held;
		logic hold_done;
		mode = RxFree;
		left = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				m_axis_tready = 1'b0;
				held = 0;
				while (held < HoldCycles) begin
					@(negedge clk);
					held++;
				end
			end
			if (left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				left = $urandom_range(20, 200);
			end
			left--;
			case (mode)
				RxFree:        m_axis_tready = 1'b1;
				RxCoin:        m_axis_tready = 1'($urandom_range(0, 1));
				RxEveryFourth: m_axis_tready = (left % 4 == 0);
				default:       m_axis_tready = ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// present one word and hold it until taken; valid stays high afterwards
	task automatic send_word(input logic kind, input logic [lcgns_pkg::WordW-1:0] seed);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				s_axis_tvalid = 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 16);
		end
		burst_left--;
		s_axis_tvalid = 1'b1;
		s_axis_tuser = kind;
		s_axis_tdata = seed;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic advance();
		send_word(lcgns_pkg::KindAdvance, $urandom);
	endtask

	task automatic reseed(input logic [lcgns_pkg::WordW-1:0] seed);
		send_word(lcgns_pkg::KindReseed, seed);
	endtask

	// stop offering, wait for every word due, then let the last advance settle
	task automatic drain();
		s_axis_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic write_reg(input logic [lcgns_pkg::IdxW-1:0] idx,
		input logic [lcgns_pkg::WordW-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == lcgns_pkg::RegModulus && val != '0)
			cur_mod = val;
	endtask

	function automatic logic [lcgns_pkg::WordW-1:0] pick_word();
		case ($urandom_range(0, 6))
			0:       return '0;
			1:       return 32'd1;
			2:       return '1;
			3:       return $urandom_range(1, 16);
			4:       return 32'd1 << $urandom_range(0, 31);
			5:       return 32'd1103515245;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [lcgns_pkg::WordW-1:0] pick_seed();
		case ($urandom_range(0, 4))
			0:       return $urandom % cur_mod;
			1:       return cur_mod - 1;
			2:       return '1;
			3:       return '0;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [lcgns_pkg::WordW-1:0] m;
		repeat (ResetCycles) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset registers: plain counter modulo 65536
		advance();
		reseed('1);
		advance();
		reseed(32'd65534);
		advance();
		drain();

		// all registers at their top, zero modulus refused, spare index ignored
		write_reg(lcgns_pkg::RegMultiplier, '1);
		write_reg(lcgns_pkg::RegIncrement, '1);
		write_reg(lcgns_pkg::RegModulus, '1);
		write_reg(lcgns_pkg::RegModulus, '0);
		write_reg(RegSpare, 32'h1234_5678);
		reseed(32'hFFFF_FFFE);
		advance();
		advance();
		advance();
		reseed('1);   // seed equal to the modulus
		advance();
		drain();

		// modulus one: every word is zero and the sample sits at minus one
		write_reg(lcgns_pkg::RegMultiplier, '0);
		write_reg(lcgns_pkg::RegIncrement, '0);
		write_reg(lcgns_pkg::RegModulus, 32'd1);
		reseed(32'hAAAA_AAAA);
		advance();
		advance();
		drain();

		write_reg(lcgns_pkg::RegMultiplier, 32'd1103515245);
		write_reg(lcgns_pkg::RegIncrement, 32'd12345);
		write_reg(lcgns_pkg::RegModulus, 32'h8000_0000);
		reseed(32'h5555_5555);
		advance();
		advance();
		advance();
		drain();

		for (int p = 0; p < Phases; p++) begin
			write_reg(lcgns_pkg::RegMultiplier, pick_word());
			write_reg(lcgns_pkg::RegIncrement, pick_word());
			m = pick_word();
			write_reg(lcgns_pkg::RegModulus, m);
			if (m == '0)
				write_reg(lcgns_pkg::RegModulus, $urandom_range(1, 1000));
			if (p == 1)
				hold_go = 1'b1;
			for (int n = 0; n < PhaseItems; n++) begin
				if ($urandom_range(0, 99) < 15)
					reseed(pick_seed());
				else
					advance();
			end
			drain();
		end

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/lcgns_pkg.sv
rtl/lcgns_dp.sv
rtl/lcgns_ctrl.sv
rtl/lcg_noise_source_unit.sv
test/lcg_noise_checker.sv
test/tb.sv
